@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the buffer's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bsfb_pkg.sv @@
package bsfb_pkg;

   localparam int DEPTH_DEFAULT       = 4096;
   localparam int SAMPLE_BITS_DEFAULT = 32;
   localparam int SAMPLE_W            = 32;
   localparam int FLUSH_W             = 16;
   // Entries of the result queue between the front and the back.
   localparam int QUEUE_DEPTH         = 4;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_TICK   = 1'b1
   } kind_type;

   typedef struct packed {
      logic                out_valid;
      logic [SAMPLE_W-1:0] out_sample;
      logic                out_sob;
      logic                out_eob;
      logic                out_ignore;
      logic                accepted;
      logic                overflow;
      logic                tag_error;
   } result_type;

   // One classified request on its way from the front to the back. When
   // from_store is set the sample word arrives from the burst store in the next cycle.
   typedef struct packed {
      logic       valid;
      logic       from_store;
      result_type result;
   } issue_type;

endpackage

@@ rtl/core/bsfb_ram.sv @@
module bsfb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/bsfb_front.sv @@
`include "assert_macros.svh"

module bsfb_front #(
   parameter int DEPTH       = bsfb_pkg::DEPTH_DEFAULT,
   parameter int SAMPLE_BITS = bsfb_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_kind,
   input  logic [bsfb_pkg::SAMPLE_W-1:0]          req_sample,
   input  logic                                   req_sob,
   input  logic                                   req_eob,
   input  logic                                   csr_we,
   input  logic [bsfb_pkg::FLUSH_W-1:0]           csr_wdata,
   input  logic                                   queue_ready,
   output bsfb_pkg::issue_type                    issue,
   output logic                                   ram_we,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ram_waddr,
   output logic [SAMPLE_BITS-1:0]                 ram_wdata,
   output logic                                   ram_re,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ram_raddr
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int FW = bsfb_pkg::FLUSH_W;

   logic [IW-1:0] write_index_ff, write_index_in;
   logic [IW-1:0] read_index_ff, read_index_in;
   logic [CW-1:0] stored_count_ff, stored_count_in;
   logic          in_burst_ff, in_burst_in;
   logic          start_pending_ff, start_pending_in;
   logic [FW-1:0] flush_left_ff, flush_left_in;
   logic [FW-1:0] flush_cfg_ff, flush_cfg_in;

   logic                 accept;
   logic                 draining;
   logic                 flushing;
   logic                 from_store;
   bsfb_pkg::result_type res;

   function automatic logic [IW-1:0] next_index(input logic [IW-1:0] idx);
      return (idx == IW'(DEPTH - 1)) ? '0 : idx + IW'(1);
   endfunction

   always_comb begin
      accept           = req_valid && queue_ready;
      draining         = (stored_count_ff != '0) && !in_burst_ff;
      flushing         = flush_left_ff != '0;
      write_index_in   = write_index_ff;
      read_index_in    = read_index_ff;
      stored_count_in  = stored_count_ff;
      in_burst_in      = in_burst_ff;
      start_pending_in = start_pending_ff;
      flush_left_in    = flush_left_ff;
      flush_cfg_in     = csr_we ? csr_wdata : flush_cfg_ff;
      res              = '0;
      from_store       = 1'b0;
      ram_we           = 1'b0;
      ram_re           = 1'b0;

      if (accept) begin
         if (req_kind == bsfb_pkg::KIND_TICK) begin
            if (draining) begin
               // Drain one stored sample; the word itself follows from the store.
               res.out_valid    = 1'b1;
               res.out_sob      = start_pending_ff;
               from_store       = 1'b1;
               ram_re           = 1'b1;
               start_pending_in = 1'b0;
               read_index_in    = next_index(read_index_ff);
               stored_count_in  = stored_count_ff - CW'(1);
               if (stored_count_ff == CW'(1)) begin
                  res.out_eob   = 1'b1;
                  flush_left_in = flush_cfg_ff;
               end
            end else if (flushing) begin
               res.out_valid = 1'b1;
               if (flush_left_ff == flush_cfg_ff) begin
                  res.out_sob    = 1'b1;
                  res.out_ignore = 1'b1;
               end
               if (flush_left_ff == FW'(1)) begin
                  res.out_eob = 1'b1;
               end
               flush_left_in = flush_left_ff - FW'(1);
            end
         end else if (!draining && !flushing) begin
            res.accepted = 1'b1;
            if (!in_burst_ff && !req_sob) begin
               res.tag_error  = req_eob;
               res.out_valid  = 1'b1;
               res.out_sample = req_sample;
            end else begin
               if (req_sob) begin
                  if (in_burst_ff) begin
                     res.tag_error = 1'b1;
                  end else begin
                     in_burst_in      = 1'b1;
                     start_pending_in = 1'b1;
                  end
               end
               if (stored_count_ff == CW'(DEPTH)) begin
                  res.overflow = 1'b1;
               end else begin
                  ram_we          = 1'b1;
                  write_index_in  = next_index(write_index_ff);
                  stored_count_in = stored_count_ff + CW'(1);
               end
               if (req_eob) begin
                  in_burst_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff   <= '0;
         read_index_ff    <= '0;
         stored_count_ff  <= '0;
         in_burst_ff      <= 1'b0;
         start_pending_ff <= 1'b0;
         flush_left_ff    <= '0;
         flush_cfg_ff     <= '0;
      end else begin
         write_index_ff   <= write_index_in;
         read_index_ff    <= read_index_in;
         stored_count_ff  <= stored_count_in;
         in_burst_ff      <= in_burst_in;
         start_pending_ff <= start_pending_in;
         flush_left_ff    <= flush_left_in;
         flush_cfg_ff     <= flush_cfg_in;
      end
   end

   assign req_ready        = queue_ready;
   assign issue.valid      = accept;
   assign issue.from_store = from_store;
   assign issue.result     = res;
   assign ram_waddr        = write_index_ff;
   assign ram_wdata        = SAMPLE_BITS'(req_sample);
   assign ram_raddr        = read_index_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, stored_count_ff <= CW'(DEPTH),
      "stored count exceeds buffer depth")
   `ASSERT_ALWAYS(a_no_rw_same_cycle, clock, reset, !(ram_we && ram_re),
      "store written and drained in the same cycle")
   `ASSERT_IMPLIES(a_drain_closed, clock, reset, ram_re,
      !in_burst_ff && (stored_count_ff != '0), "drain issued while burst still open")

endmodule

@@ rtl/core/bsfb_back.sv @@
`include "assert_macros.svh"

module bsfb_back #(
   parameter int SAMPLE_BITS = bsfb_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bsfb_pkg::issue_type    issue,
   input  logic [SAMPLE_BITS-1:0] ram_rdata,
   output logic                   queue_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bsfb_pkg::result_type   rsp
);

   localparam int QD  = bsfb_pkg::QUEUE_DEPTH;
   localparam int QIW = (QD > 1) ? $clog2(QD) : 1;
   localparam int QCW = $clog2(QD + 1);

   logic                 s1_valid_ff;
   logic                 s1_from_store_ff;
   bsfb_pkg::result_type s1_result_ff;
   bsfb_pkg::result_type merged;

   bsfb_pkg::result_type entry_ff [QD];
   logic [QIW-1:0]       head_ff, head_in;
   logic [QIW-1:0]       tail_ff, tail_in;
   logic [QCW-1:0]       count_ff, count_in;
   logic                 push;
   logic                 pop;

   always_comb begin
      merged = s1_result_ff;
      if (s1_from_store_ff) begin
         merged.out_sample = bsfb_pkg::SAMPLE_W'(ram_rdata);
      end
      push      = s1_valid_ff;
      rsp_valid = count_ff != '0;
      pop       = rsp_valid && rsp_ready;
      head_in   = pop ? head_ff + QIW'(1) : head_ff;
      tail_in   = push ? tail_ff + QIW'(1) : tail_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QCW'(1);
         2'b01:   count_in = count_ff - QCW'(1);
         default: count_in = count_ff;
      endcase
      // Room is counted against the stage register as well as the queue.
      queue_ready = ({1'b0, count_ff} + (QCW + 1)'(s1_valid_ff)) < (QCW + 1)'(QD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= issue.valid;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_from_store_ff <= issue.from_store;
      s1_result_ff     <= issue.result;
      if (push) begin
         entry_ff[tail_ff] <= merged;
      end
   end

   assign rsp = entry_ff[head_ff];

   `ASSERT_ALWAYS(a_queue_bound, clock, reset, count_ff <= QCW'(QD),
      "result queue count exceeds its depth")
   `ASSERT_IMPLIES(a_push_room, clock, reset, s1_valid_ff, count_ff < QCW'(QD),
      "result pushed into a full queue")
   `ASSERT_NEXT(a_pop_drains, clock, reset, pop && !push,
      count_ff == $past(count_ff) - QCW'(1), "queue count did not fall after a pop")

endmodule

@@ rtl/core/burst_store_and_forward_buffer.sv @@
// Store-and-forward burst buffer for a transmit sample stream. Each request is
// either an offered sample (kind 0) or an output-slot tick (kind 1) and yields
// exactly one response, in order. Samples outside a burst pass straight through;
// a burst opened by sob and closed by eob is written into the burst store, then
// drained one word per tick with sob on the first and eob on the last word,
// followed by the configured number of zero words (sob and ignore on the first,
// eob on the last). Offers made while draining or flushing come back with
// accepted low and should be retried. A full store drops the burst sample and
// sets overflow; a misplaced sob or eob sets tag_error. The block takes one
// request every clock cycle while req_ready is high, and an accepted request
// passes through the stage register that waits for the registered read port
// of the burst store and then enters the response queue.
// A four-entry response queue lets both sides stall independently; req_ready
// drops only when the queue, together with the request waiting in its feeding
// stage, would hold four responses. The store needs no clearing pass after
// reset. The flush length is written through csr_we and csr_wdata and should
// only be changed while no requests are in flight.
module burst_store_and_forward_buffer #(
   parameter int DEPTH       = bsfb_pkg::DEPTH_DEFAULT,
   parameter int SAMPLE_BITS = bsfb_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [bsfb_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          req_sob,
   input  logic                          req_eob,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_out_valid,
   output logic [bsfb_pkg::SAMPLE_W-1:0] rsp_out_sample,
   output logic                          rsp_out_sob,
   output logic                          rsp_out_eob,
   output logic                          rsp_out_ignore,
   output logic                          rsp_accepted,
   output logic                          rsp_overflow,
   output logic                          rsp_tag_error,
   input  logic                          csr_we,
   input  logic [bsfb_pkg::FLUSH_W-1:0]  csr_wdata
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Front to back: one classified request per accepted cycle.
   bsfb_pkg::issue_type  issue;
   bsfb_pkg::result_type rsp;
   logic                 queue_ready;

   // Burst store ports.
   logic                   ram_we;
   logic [IW-1:0]          ram_waddr;
   logic [SAMPLE_BITS-1:0] ram_wdata;
   logic                   ram_re;
   logic [IW-1:0]          ram_raddr;
   logic [SAMPLE_BITS-1:0] ram_rdata;

   // The front holds the burst state, the store pointers and the flush counter,
   // and decides for each request what it does and what it returns.
   bsfb_front #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_sample  (req_sample),
      .req_sob     (req_sob),
      .req_eob     (req_eob),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .queue_ready (queue_ready),
      .issue       (issue),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr)
   );

   // The burst store itself: one write and one registered read port.
   bsfb_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The back merges drained words into their responses and queues them for
   // the response channel.
   bsfb_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .ram_rdata   (ram_rdata),
      .queue_ready (queue_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

   assign rsp_out_valid  = rsp.out_valid;
   assign rsp_out_sample = rsp.out_sample;
   assign rsp_out_sob    = rsp.out_sob;
   assign rsp_out_eob    = rsp.out_eob;
   assign rsp_out_ignore = rsp.out_ignore;
   assign rsp_accepted   = rsp.accepted;
   assign rsp_overflow   = rsp.overflow;
   assign rsp_tag_error  = rsp.tag_error;

endmodule
